/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; expect clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sfps_pkg.sv */
// ---------------------------------------------------------------------------
// sfps_pkg
// Types, constants and twiddle function for the stereo FFT power spectrum.
// ---------------------------------------------------------------------------
`default_nettype none

package sfps_pkg;

	localparam int FFT_POINTS_DEF = 512;
	localparam int FFT_STAGES_DEF = 9;
	localparam int DATA_W         = 36;
	localparam int TW_W           = 18;
	localparam int SAMPLE_W       = 16;
	localparam int POWER_W        = 56;
	localparam int BIN_W          = 12;
	localparam int ACC_W          = 72;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [2:0] MUL_LAST = 3'd4;
	localparam logic [2:0] SQ_LAST  = 3'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BF_RD,
		ST_BF_MUL,
		ST_BF_ADD,
		ST_BF_WRB,
		ST_PW_RD,
		ST_PW_ABS,
		ST_PW_MUL,
		ST_EMIT_BIN,
		ST_EMIT_ZERO
	} state_t;

	typedef struct packed {
		logic       wr_push;
		logic       wr_sum;
		logic       wr_diff;
		logic       rd_a;
		logic       rd_b;
		logic       tw_ld;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       abs_ld;
		logic       sq_en;
		logic       sq_sel;
		logic       out_load;
		logic       out_zero;
		logic       edge_bin;
	} cmd_t;

	// {cos, sin} of an angle in radians, Q2.16, rounded to nearest
	function automatic logic [2*TW_W-1:0] tw_entry(real ang);
		int c;
		int s;
		c = $rtoi($floor($cos(ang) * 65536.0 + 0.5));
		s = $rtoi($floor($sin(ang) * 65536.0 + 0.5));
		return {TW_W'(c), TW_W'(s)};
	endfunction

endpackage

`default_nettype wire

/* rtl/stereo_fft_power_spectrum_core.sv */
// ---------------------------------------------------------------------------
// stereo_fft_power_spectrum_core
// Stereo frame averaging, in-place radix-2 FFT and power bin readout.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall): command 0 transfers one stereo frame,
// command 1 asks for the next power bin. Output channel (out_valid/out_stall)
// carries power, bin_index, last_bin and available.
// A push is written to the store as it is taken and does not stall the input;
// the FFT_POINTS-th push starts the transform, which runs on one butterfly
// unit, FFT_POINTS/2 * FFT_STAGES butterflies; in_stall is high for that
// time, as in every state but idle; the single store write port is shared.
// A bin read passes through store read, absolute value, squaring and emit
// states before its result is loaded; with no spectrum ready, a read loads
// a zero result; a bin read occupies the block until the result is loaded.
// Reset clears control state; the sample store is left as is and every entry
// is written before it is read. While the receiver stalls, the result is held
// and pushes are still taken; a read's result waits until the output register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module stereo_fft_power_spectrum_core #(
	parameter int FFT_POINTS = sfps_pkg::FFT_POINTS_DEF,
	parameter int FFT_STAGES = sfps_pkg::FFT_STAGES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 command,
	input  logic signed [sfps_pkg::SAMPLE_W-1:0] sample_left,
	input  logic signed [sfps_pkg::SAMPLE_W-1:0] sample_right,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [sfps_pkg::POWER_W-1:0]         power,
	output logic [sfps_pkg::BIN_W-1:0]           bin_index,
	output logic                                 last_bin,
	output logic                                 available
);

	import sfps_pkg::*;

	cmd_t                  cmd;
	logic [FFT_STAGES-1:0] wr_addr, rd_addr_a, rd_addr_b;
	logic [FFT_STAGES-2:0] tw_idx;
	logic [BIN_W-1:0]      bin;
	logic                  last;

	sfps_ctrl #(
		.FFT_POINTS (FFT_POINTS),
		.FFT_STAGES (FFT_STAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.tw_idx    (tw_idx),
		.bin       (bin),
		.last      (last)
	);

	sfps_dp #(
		.FFT_POINTS (FFT_POINTS),
		.FFT_STAGES (FFT_STAGES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.wr_addr      (wr_addr),
		.rd_addr_a    (rd_addr_a),
		.rd_addr_b    (rd_addr_b),
		.tw_idx       (tw_idx),
		.bin          (bin),
		.last         (last),
		.power        (power),
		.bin_index    (bin_index),
		.last_bin     (last_bin),
		.available    (available)
	);

endmodule

`default_nettype wire

/* rtl/sfps_ram.sv */
// ---------------------------------------------------------------------------
// sfps_ram
// Generic RAM: one write port, two read ports with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module sfps_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic                     re_b,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

/* rtl/sfps_ctrl.sv */
// ---------------------------------------------------------------------------
// sfps_ctrl
// Controller: sequencing of push, transform butterflies and bin reads.
// ---------------------------------------------------------------------------
`default_nettype none

module sfps_ctrl #(
	parameter int FFT_POINTS = sfps_pkg::FFT_POINTS_DEF,
	parameter int FFT_STAGES = sfps_pkg::FFT_STAGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        command,
	output logic                        out_valid,
	input  logic                        out_stall,
	output sfps_pkg::cmd_t              cmd,
	output logic [FFT_STAGES-1:0]       wr_addr,
	output logic [FFT_STAGES-1:0]       rd_addr_a,
	output logic [FFT_STAGES-1:0]       rd_addr_b,
	output logic [FFT_STAGES-2:0]       tw_idx,
	output logic [sfps_pkg::BIN_W-1:0]  bin,
	output logic                        last
);

	import sfps_pkg::*;

	localparam int ST       = FFT_STAGES;
	localparam int SW       = $clog2(ST);
	localparam int HALF_PTS = FFT_POINTS / 2;

	state_t          state_q, state_d;
	logic [SW-1:0]   stage_q;
	logic [ST-2:0]   bf_q;
	logic [2:0]      cnt_q;
	logic [ST-1:0]   frames_q;
	logic [ST-1:0]   rp_q;
	logic            ready_q;
	logic            out_valid_q;

	logic [ST-1:0]   bx, mask, jx, k0, k1, span, brev;
	logic            out_free, frame_last, bf_last, stage_last, push_acc;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign bx   = ST'(bf_q);
	assign span = ST'(1) << stage_q;
	assign mask = span - ST'(1);
	assign jx   = bx & mask;
	assign k0   = (((bx >> stage_q) << 1) << stage_q) | jx;
	assign k1   = k0 | span;
	assign tw_idx = (ST-1)'(jx << (SW'(ST-1) - stage_q));

	always_comb begin
		for (int i = 0; i < ST; i++) begin
			brev[i] = frames_q[ST-1-i];
		end
	end

	assign frame_last = (frames_q == ST'(FFT_POINTS-1));
	assign bf_last    = (bf_q == '1);
	assign stage_last = (stage_q == SW'(ST-1));
	assign push_acc   = (state_q == ST_IDLE) && in_valid && (command == CMD_PUSH);

	assign last      = (rp_q == ST'(HALF_PTS));
	assign bin       = BIN_W'(rp_q);
	assign rd_addr_a = (state_q == ST_PW_RD) ? rp_q : k0;
	assign rd_addr_b = k1;

	always_comb begin
		unique case (state_q)
			ST_BF_ADD: wr_addr = k0;
			ST_BF_WRB: wr_addr = k1;
			default:   wr_addr = brev;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (command == CMD_PUSH) begin
						if (frame_last) state_d = ST_BF_RD;
					end else if (ready_q) begin
						state_d = ST_PW_RD;
					end else begin
						state_d = ST_EMIT_ZERO;
					end
				end
			end
			ST_BF_RD:  state_d = ST_BF_MUL;
			ST_BF_MUL: if (cnt_q == MUL_LAST) state_d = ST_BF_ADD;
			ST_BF_ADD: state_d = ST_BF_WRB;
			ST_BF_WRB: state_d = (bf_last && stage_last) ? ST_IDLE : ST_BF_RD;
			ST_PW_RD:  state_d = ST_PW_ABS;
			ST_PW_ABS: state_d = ST_PW_MUL;
			ST_PW_MUL: if (cnt_q == SQ_LAST) state_d = ST_EMIT_BIN;
			ST_EMIT_BIN, ST_EMIT_ZERO: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:      cmd.wr_push = push_acc;
			ST_BF_RD: begin
				cmd.rd_a  = 1'b1;
				cmd.rd_b  = 1'b1;
				cmd.tw_ld = 1'b1;
			end
			ST_BF_MUL: begin
				cmd.mul_en  = (cnt_q < MUL_LAST);
				cmd.mul_sel = cnt_q[1:0];
			end
			ST_BF_ADD:    cmd.wr_sum = 1'b1;
			ST_BF_WRB:    cmd.wr_diff = 1'b1;
			ST_PW_RD:     cmd.rd_a = 1'b1;
			ST_PW_ABS:    cmd.abs_ld = 1'b1;
			ST_PW_MUL: begin
				cmd.sq_en  = (cnt_q < SQ_LAST);
				cmd.sq_sel = cnt_q[0];
			end
			ST_EMIT_BIN: begin
				cmd.out_load = out_free;
				cmd.edge_bin = (rp_q == '0) || last;
			end
			ST_EMIT_ZERO: begin
				cmd.out_load = out_free;
				cmd.out_zero = 1'b1;
			end
			default:      cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stage_q     <= '0;
			bf_q        <= '0;
			cnt_q       <= '0;
			frames_q    <= '0;
			rp_q        <= '0;
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_BF_MUL || state_q == ST_PW_MUL) begin
				cnt_q <= cnt_q + 3'd1;
			end else begin
				cnt_q <= '0;
			end
			if (push_acc) begin
				ready_q  <= 1'b0;
				frames_q <= frame_last ? '0 : frames_q + ST'(1);
			end
			if (state_q == ST_BF_WRB) begin
				if (bf_last) begin
					bf_q    <= '0;
					stage_q <= stage_last ? '0 : stage_q + SW'(1);
					if (stage_last) begin
						ready_q <= 1'b1;
						rp_q    <= '0;
					end
				end else begin
					bf_q <= bf_q + (ST-1)'(1);
				end
			end
			if (state_q == ST_EMIT_BIN && out_free) begin
				if (last) begin
					ready_q <= 1'b0;
					rp_q    <= '0;
				end else begin
					rp_q <= rp_q + ST'(1);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/sfps_dp.sv */
// ---------------------------------------------------------------------------
// sfps_dp
// Datapath: sample store, butterfly arithmetic, power and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module sfps_dp #(
	parameter int FFT_POINTS = sfps_pkg::FFT_POINTS_DEF,
	parameter int FFT_STAGES = sfps_pkg::FFT_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sfps_pkg::cmd_t                      cmd,
	input  logic signed [sfps_pkg::SAMPLE_W-1:0] sample_left,
	input  logic signed [sfps_pkg::SAMPLE_W-1:0] sample_right,
	input  logic [FFT_STAGES-1:0]               wr_addr,
	input  logic [FFT_STAGES-1:0]               rd_addr_a,
	input  logic [FFT_STAGES-1:0]               rd_addr_b,
	input  logic [FFT_STAGES-2:0]               tw_idx,
	input  logic [sfps_pkg::BIN_W-1:0]          bin,
	input  logic                                last,
	output logic [sfps_pkg::POWER_W-1:0]        power,
	output logic [sfps_pkg::BIN_W-1:0]          bin_index,
	output logic                                last_bin,
	output logic                                available
);

	import sfps_pkg::*;

	localparam int HALF = FFT_POINTS / 2;
	localparam int MW   = 2 * DATA_W;

	logic [MW-1:0]         wdata, rdata_a, rdata_b, diff_q;
	logic                  we;
	logic signed [16:0]    sum17, avg17;
	logic [DATA_W-1:0]     push_re;

	logic [2*TW_W-1:0]     tw_rom [HALF];
	logic [2*TW_W-1:0]     tw_q;

	logic signed [TW_W-1:0]   mtw;
	logic [DATA_W-1:0]        mdat;
	logic signed [35:0]       ph_s1;
	logic signed [36:0]       pl_s1;
	logic                     mv_s1;
	logic [1:0]               msel_s1;
	logic signed [53:0]       full, rnd;
	logic [DATA_W-1:0]        prod_q [4];
	logic [DATA_W-1:0]        tr, ti, ar, ai;

	logic [DATA_W-1:0]        abs_re_q, abs_im_q, sx, re_v, im_v;
	logic [35:0]              hh_s1, hl_s1, ll_s1;
	logic                     sv_s1;
	logic [ACC_W-1:0]         sq, acc_q, shifted;
	logic [POWER_W-1:0]       pw;

	logic [POWER_W-1:0]       power_q;
	logic [BIN_W-1:0]         bin_q;
	logic                     last_q, avail_q;

	for (genvar g = 0; g < HALF; g++) begin : g_tw
		localparam real ANG = 6.283185307179586 * g / FFT_POINTS;
		assign tw_rom[g] = tw_entry(ANG);
	end

	assign sum17   = {sample_left[SAMPLE_W-1], sample_left}
	               + {sample_right[SAMPLE_W-1], sample_right};
	assign avg17   = (sum17 + $signed(17'(sum17[16]))) >>> 1;
	assign push_re = {{11{avg17[16]}}, avg17, 8'b0};

	assign ar = rdata_a[MW-1:DATA_W];
	assign ai = rdata_a[DATA_W-1:0];
	assign tr = prod_q[0] - prod_q[1];
	assign ti = prod_q[2] + prod_q[3];

	assign we = cmd.wr_push | cmd.wr_sum | cmd.wr_diff;
	always_comb begin
		priority if (cmd.wr_push) begin
			wdata = {push_re, {DATA_W{1'b0}}};
		end else if (cmd.wr_sum) begin
			wdata = {ar + tr, ai + ti};
		end else begin
			wdata = diff_q;
		end
	end

	sfps_ram #(
		.WIDTH (MW),
		.DEPTH (FFT_POINTS)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (wr_addr),
		.wdata   (wdata),
		.re_a    (cmd.rd_a),
		.raddr_a (rd_addr_a),
		.rdata_a (rdata_a),
		.re_b    (cmd.rd_b),
		.raddr_b (rd_addr_b),
		.rdata_b (rdata_b)
	);

	assign mtw  = cmd.mul_sel[0] ? tw_q[TW_W-1:0] : tw_q[2*TW_W-1:TW_W];
	assign mdat = (cmd.mul_sel[0] ^ cmd.mul_sel[1]) ? rdata_b[DATA_W-1:0]
	                                                : rdata_b[MW-1:DATA_W];
	assign full = {ph_s1, 18'b0} + {{17{pl_s1[36]}}, pl_s1};
	assign rnd  = full + 54'sd32768;

	assign re_v = ar[DATA_W-1] ? (~ar + DATA_W'(1)) : ar;
	assign im_v = ai[DATA_W-1] ? (~ai + DATA_W'(1)) : ai;
	assign sx   = cmd.sq_sel ? abs_im_q : abs_re_q;
	assign sq   = {hh_s1, 36'b0} + {17'b0, hl_s1, 19'b0} + {36'b0, ll_s1};

	assign shifted = cmd.edge_bin ? (acc_q >> 18) : (acc_q >> 16);
	assign pw      = (|shifted[ACC_W-1:POWER_W]) ? {POWER_W{1'b1}} : shifted[POWER_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1   <= 1'b0;
			sv_s1   <= 1'b0;
			avail_q <= 1'b0;
		end else begin
			mv_s1 <= cmd.mul_en;
			sv_s1 <= cmd.sq_en;
			if (cmd.out_load) avail_q <= !cmd.out_zero;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tw_ld) tw_q <= tw_rom[tw_idx];
		if (cmd.mul_en) begin
			ph_s1   <= mtw * $signed(mdat[DATA_W-1:18]);
			pl_s1   <= mtw * $signed({1'b0, mdat[17:0]});
			msel_s1 <= cmd.mul_sel;
		end
		if (mv_s1) prod_q[msel_s1] <= rnd[51:16];
		if (cmd.wr_sum) diff_q <= {ar - tr, ai - ti};
		if (cmd.abs_ld) begin
			abs_re_q <= re_v;
			abs_im_q <= im_v;
			acc_q    <= '0;
		end else if (sv_s1) begin
			acc_q <= acc_q + sq;
		end
		if (cmd.sq_en) begin
			hh_s1 <= sx[35:18] * sx[35:18];
			hl_s1 <= sx[35:18] * sx[17:0];
			ll_s1 <= sx[17:0] * sx[17:0];
		end
		if (cmd.out_load) begin
			power_q <= cmd.out_zero ? '0 : pw;
			bin_q   <= cmd.out_zero ? '0 : bin;
			last_q  <= cmd.out_zero ? 1'b0 : last;
		end
	end

	assign power     = power_q;
	assign bin_index = bin_q;
	assign last_bin  = last_q;
	assign available = avail_q;

endmodule

`default_nettype wire

/* rtl/sfps_checker.sv */
// ---------------------------------------------------------------------------
// sfps_checker
// Port-level assertions for the stereo FFT power spectrum core.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sfps_checker #(
	parameter int FFT_POINTS = sfps_pkg::FFT_POINTS_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic                                 command,
	input logic signed [sfps_pkg::SAMPLE_W-1:0] sample_left,
	input logic signed [sfps_pkg::SAMPLE_W-1:0] sample_right,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic [sfps_pkg::POWER_W-1:0]         power,
	input logic [sfps_pkg::BIN_W-1:0]           bin_index,
	input logic                                 last_bin,
	input logic                                 available
);

	import sfps_pkg::*;

	localparam int HALF_PTS = FFT_POINTS / 2;

	`ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(command) && $stable(sample_left) && $stable(sample_right), "stalled input changed")
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(power), "stalled result changed")
	`ASSERT_IMPL(a_empty_zero, out_valid && !available, power == '0 && bin_index == '0 && !last_bin, "empty read not zero")
	`ASSERT_IMPL(a_last_index, out_valid && last_bin, available && bin_index == BIN_W'(HALF_PTS), "last bin index wrong")
	`ASSERT_IMPL(a_first_not_last, out_valid && available && bin_index == '0, !last_bin, "bin zero flagged last")

endmodule

bind stereo_fft_power_spectrum_core sfps_checker #(.FFT_POINTS(FFT_POINTS)) u_sfps_checker (.*);

`default_nettype wire
